// ----- design/ufdtd_pkg.sv -----
// ----------------------------------------------------------------------------
// ufdtd_pkg
// shared types, constants and decode helpers for the frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package ufdtd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned TouchWidth = 2;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned RspDataWidth = 24;

   localparam logic [ByteWidth-1:0] SyncFirstReset    = 8'h55;
   localparam logic [ByteWidth-1:0] SyncSecondReset   = 8'hAA;
   localparam logic [ByteWidth-1:0] TrailerValueReset = 8'h45;
   localparam logic [ByteWidth-1:0] MaxPayloadReset   = 8'd23;
   localparam logic [ByteWidth-1:0] SyncSecondMask    = 8'hFE;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SYNC_FIRST    = 2'd0,
      CSR_SYNC_SECOND   = 2'd1,
      CSR_TRAILER_VALUE = 2'd2,
      CSR_MAX_PAYLOAD   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_TYPE    = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_TRAILER = 3'd5
   } phase_type;

   typedef enum logic [TouchWidth-1:0] {
      TOUCH_EV_LEFT  = 2'd0,
      TOUCH_EV_RIGHT = 2'd1,
      TOUCH_NONE     = 2'd2
   } touch_type;

   localparam logic [ByteWidth-1:0] TypeUp    = 8'd0;
   localparam logic [ByteWidth-1:0] TypeDown  = 8'd1;
   localparam logic [ByteWidth-1:0] TypeLeft  = 8'd2;
   localparam logic [ByteWidth-1:0] TypeRight = 8'd3;

   typedef struct packed {
      logic [ByteWidth-1:0] sync_first;
      logic [ByteWidth-1:0] sync_second;
      logic [ByteWidth-1:0] trailer_value;
      logic [ByteWidth-1:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic                 frame_good;
      logic [ByteWidth-1:0] packet_type;
      logic [ByteWidth-1:0] payload_length;
      touch_type            touch_event;
   } result_type;

   function automatic touch_type touch_of_type(input logic [ByteWidth-1:0] t);
      touch_type r;
      case (t)
         TypeUp:    r = TOUCH_EV_RIGHT;
         TypeRight: r = TOUCH_EV_RIGHT;
         TypeDown:  r = TOUCH_EV_LEFT;
         TypeLeft:  r = TOUCH_EV_LEFT;
         default:   r = TOUCH_NONE;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/ufdtd_csr.sv -----
// ----------------------------------------------------------------------------
// ufdtd_csr
// configuration registers, written through the plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module ufdtd_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [ufdtd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [ufdtd_pkg::ByteWidth-1:0]       csr_wdata,
   output ufdtd_pkg::cfg_type                         cfg
);

   ufdtd_pkg::cfg_type cfg_ff;
   ufdtd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (ufdtd_pkg::csr_index_type'(csr_index))
            ufdtd_pkg::CSR_SYNC_FIRST:    cfg_in.sync_first    = csr_wdata;
            ufdtd_pkg::CSR_SYNC_SECOND:   cfg_in.sync_second   = csr_wdata;
            ufdtd_pkg::CSR_TRAILER_VALUE: cfg_in.trailer_value = csr_wdata;
            ufdtd_pkg::CSR_MAX_PAYLOAD:   cfg_in.max_payload   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= ufdtd_pkg::SyncFirstReset;
         cfg_ff.sync_second   <= ufdtd_pkg::SyncSecondReset;
         cfg_ff.trailer_value <= ufdtd_pkg::TrailerValueReset;
         cfg_ff.max_payload   <= ufdtd_pkg::MaxPayloadReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/ufdtd_parser.sv -----
// ----------------------------------------------------------------------------
// ufdtd_parser
// input byte register and frame state machine, one byte per cycle while a trailer byte is not held by res_ready
// ----------------------------------------------------------------------------
`default_nettype none

module ufdtd_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output      logic                              in_ready,
   input  wire logic [ufdtd_pkg::ByteWidth-1:0]   in_byte,
   input  wire ufdtd_pkg::cfg_type                cfg,
   output      logic                              res_valid,
   input  wire logic                              res_ready,
   output ufdtd_pkg::result_type                  res
);

   logic                            byte_valid_ff;
   logic                            byte_valid_in;
   logic [ufdtd_pkg::ByteWidth-1:0] byte_ff;

   ufdtd_pkg::phase_type            phase_ff;
   ufdtd_pkg::phase_type            phase_in;
   logic [ufdtd_pkg::ByteWidth-1:0] sync2_ff;
   logic [ufdtd_pkg::ByteWidth-1:0] sync2_in;
   logic [ufdtd_pkg::ByteWidth-1:0] type_ff;
   logic [ufdtd_pkg::ByteWidth-1:0] type_in;
   logic [ufdtd_pkg::ByteWidth-1:0] length_ff;
   logic [ufdtd_pkg::ByteWidth-1:0] length_in;
   logic [ufdtd_pkg::ByteWidth-1:0] count_ff;
   logic [ufdtd_pkg::ByteWidth-1:0] count_in;

   logic                            emits;
   logic                            advance;
   logic [ufdtd_pkg::ByteWidth-1:0] count_next;
   logic                            good;

   assign emits      = byte_valid_ff && (phase_ff == ufdtd_pkg::PH_TRAILER);
   assign advance    = byte_valid_ff && (!emits || res_ready);
   assign in_ready   = !byte_valid_ff || advance;
   assign count_next = count_ff + 8'd1;
   assign good       = (byte_ff == cfg.trailer_value);

   assign res_valid          = emits;
   assign res.frame_good     = good;
   assign res.packet_type    = type_ff;
   assign res.payload_length = length_ff;
   assign res.touch_event    = good ? ufdtd_pkg::touch_of_type(type_ff)
                                    : ufdtd_pkg::TOUCH_NONE;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (in_ready) begin
         byte_valid_in = in_valid;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      sync2_in  = sync2_ff;
      type_in   = type_ff;
      length_in = length_ff;
      count_in  = count_ff;
      if (advance) begin
         case (phase_ff)
            ufdtd_pkg::PH_IDLE: begin
               if (byte_ff == cfg.sync_first) begin
                  phase_in = ufdtd_pkg::PH_SYNC2;
               end
            end
            ufdtd_pkg::PH_SYNC2: begin
               sync2_in = byte_ff;
               phase_in = ufdtd_pkg::PH_TYPE;
            end
            ufdtd_pkg::PH_TYPE: begin
               type_in  = byte_ff;
               phase_in = ufdtd_pkg::PH_LENGTH;
            end
            ufdtd_pkg::PH_LENGTH: begin
               length_in = byte_ff;
               if (((sync2_ff & ufdtd_pkg::SyncSecondMask) != cfg.sync_second) ||
                   (byte_ff > cfg.max_payload)) begin
                  phase_in = ufdtd_pkg::PH_IDLE;
               end else if (byte_ff == '0) begin
                  phase_in = ufdtd_pkg::PH_TRAILER;
               end else begin
                  count_in = '0;
                  phase_in = ufdtd_pkg::PH_PAYLOAD;
               end
            end
            ufdtd_pkg::PH_PAYLOAD: begin
               count_in = count_next;
               if (count_next == length_ff) begin
                  phase_in = ufdtd_pkg::PH_TRAILER;
               end
            end
            ufdtd_pkg::PH_TRAILER: begin
               phase_in = ufdtd_pkg::PH_IDLE;
            end
            default: begin
               phase_in = ufdtd_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         phase_ff      <= ufdtd_pkg::PH_IDLE;
         sync2_ff      <= '0;
         type_ff       <= '0;
         length_ff     <= '0;
         count_ff      <= '0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         phase_ff      <= phase_in;
         sync2_ff      <= sync2_in;
         type_ff       <= type_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
      end
   end

endmodule

`default_nettype wire

// ----- design/ufdtd_out_reg.sv -----
// ----------------------------------------------------------------------------
// ufdtd_out_reg
// result register holding one finished frame summary for the rsp side
// ----------------------------------------------------------------------------
`default_nettype none

module ufdtd_out_reg (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  res_valid,
   output      logic                                  res_ready,
   input  wire ufdtd_pkg::result_type                 res,
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output      logic [ufdtd_pkg::RspDataWidth-1:0]    rsp_tdata
);

   logic                  valid_ff;
   logic                  valid_in;
   ufdtd_pkg::result_type data_ff;

   assign res_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (res_ready) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, data_ff.touch_event, data_ff.payload_length,
                        data_ff.packet_type, data_ff.frame_good};

endmodule

`default_nettype wire

// ----- design/uart_frame_deframer_touch_decode.sv -----
// ----------------------------------------------------------------------------
// uart_frame_deframer_touch_decode
// length-prefixed frame deframer for a received byte stream with touch decode
// ----------------------------------------------------------------------------
//  port group  dir  contents
//  req_*       in   one received byte per beat
//  rsp_*       out  one summary beat per frame that reaches its trailer byte
//  csr_*       in   register writes: sync_first, sync_second, trailer, max
//
//  one byte per cycle while rsp does not hold back a trailer byte; a byte is held
//  in the input register and its result, if any, is then registered in the output register for rsp
//  the frame state machine advances once per byte, set by the input register
//  a stalled rsp side holds back a trailer byte and the bytes behind it; earlier bytes keep flowing
//  synchronous reset restores register defaults and returns to idle
// ----------------------------------------------------------------------------
`default_nettype none

module uart_frame_deframer_touch_decode (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [ufdtd_pkg::ByteWidth-1:0]       req_tdata,  // rx_byte
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // frame_good, packet_type, payload_length, touch_event, zero pad
   output      logic [ufdtd_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [ufdtd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [ufdtd_pkg::ByteWidth-1:0]       csr_wdata
);

   ufdtd_pkg::cfg_type    cfg;
   ufdtd_pkg::result_type res;
   logic                  res_valid;
   logic                  res_ready;

   ufdtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ufdtd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   ufdtd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
